>>> design/assert_macros.svh
// Assertion macros used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_RAW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)

`define ASSERT_RAW(lbl, clk, prop, msg)

`endif

`endif

>>> design/ebb_pkg.sv
package ebb_pkg;

  localparam int NUM_CONTEXTS = 16;
  localparam int NUM_ACTIONS  = 8;

  localparam int TBL_DEPTH = NUM_CONTEXTS * NUM_ACTIONS;
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CTX_IDX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int ACT_W     = 3;
  localparam int CNT_W     = $clog2(NUM_ACTIONS + 1);
  localparam int VAL_W     = 16;
  localparam int VIS_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [7:0] ACT_MASK = 8'((1 << NUM_ACTIONS) - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd2;

  localparam logic [0:0] OP_SELECT = 1'b0;
  localparam logic [0:0] OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [0:0]        operation;
    logic [7:0]        context_req;
    logic [7:0]        feasible_mask;
    logic [15:0]       rand_explore;
    logic [15:0]       rand_pick;
    logic [3:0]        taken_action;
    logic signed [15:0] reward;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic signed [15:0] new_value;
    logic [31:0]        visit_total;
    logic               update_ignored;
  } out_item_t;

  typedef struct packed {
    logic [15:0] epsilon;
    logic [15:0] alpha;
    logic [2:0]  fallback_action;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_GREEDY = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CTX_IDX_W-1:0]  ctx;
    logic [7:0]            mask;
    logic [ACT_W-1:0]      action;
    logic signed [15:0]    reward;
    out_item_t             res;
  } q_item_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_URD   = 7'b0001000,
    S_UMUL  = 7'b0010000,
    S_UWR   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } back_state_t;

endpackage

>>> design/ebb_ram.sv
module ebb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/ebb_front.sv
module ebb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ebb_pkg::cfg_t     cfg,
  input  logic              hold,
  input  logic              in_push,
  output logic              in_full,
  input  ebb_pkg::in_item_t in_item,
  output ebb_pkg::q_item_t  q_item,
  output logic              q_empty,
  input  logic              q_pop
);
  import ebb_pkg::*;

  q_item_t              q_mem_r [2];
  logic                 wp_r, wp_nxt;
  logic                 rp_r, rp_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 accept;
  logic                 do_pop;

  q_item_t              cls;
  logic [7:0]           mask_f;
  logic [CNT_W-1:0]     n_feas;
  logic [CNT_W-1:0]     seen;
  logic [CNT_W-1:0]     pick_idx;
  logic [16+CNT_W-1:0]  pick_prod;
  logic [ACT_W-1:0]     first_act;
  logic [ACT_W-1:0]     pick_act;
  logic [CTX_IDX_W-1:0] ctx;

  always_comb begin
    mask_f = in_item.feasible_mask & ACT_MASK;
    n_feas = '0;
    first_act = '0;
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      if (mask_f[a]) begin
        if (n_feas == '0) begin
          first_act = ACT_W'(a);
        end
        n_feas = n_feas + 1'b1;
      end
    end
    pick_prod = (16+CNT_W)'(in_item.rand_pick) * (16+CNT_W)'(n_feas);
    pick_idx  = pick_prod[16 +: CNT_W];
    seen = '0;
    pick_act = '0;
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      if (mask_f[a]) begin
        if (seen == pick_idx) begin
          pick_act = ACT_W'(a);
        end
        seen = seen + 1'b1;
      end
    end
    if (32'(in_item.context_req) > 32'(NUM_CONTEXTS - 1)) begin
      ctx = CTX_IDX_W'(NUM_CONTEXTS - 1);
    end else begin
      ctx = in_item.context_req[CTX_IDX_W-1:0];
    end

    cls        = '0;
    cls.ctx    = ctx;
    cls.mask   = mask_f;
    cls.reward = in_item.reward;
    cls.action = in_item.taken_action[ACT_W-1:0];
    cls.kind   = KIND_DONE;
    if (in_item.operation == OP_UPDATE) begin
      if (32'(in_item.taken_action) >= 32'(NUM_ACTIONS)) begin
        cls.res.update_ignored = 1'b1;
      end else begin
        cls.kind = KIND_UPDATE;
      end
    end else if (n_feas == '0) begin
      cls.res.chosen_action = cfg.fallback_action;
    end else if (n_feas == CNT_W'(1)) begin
      cls.res.chosen_action = first_act;
    end else if (in_item.rand_explore < cfg.epsilon) begin
      cls.res.chosen_action = pick_act;
      cls.res.explored      = 1'b1;
    end else begin
      cls.kind = KIND_GREEDY;
    end
  end

  assign in_full = hold || (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_item  = q_mem_r[rp_r];
  assign accept  = in_push && !in_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wp_nxt  = accept ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, accept} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wp_r] <= cls;
    end
  end

endmodule

>>> design/ebb_back.sv
module ebb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ebb_pkg::cfg_t      cfg,
  input  ebb_pkg::q_item_t   q_item,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_empty,
  input  logic               out_pop,
  output ebb_pkg::out_item_t out_item
);
  import ebb_pkg::*;

  back_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  q_item_t             cur_r, cur_nxt;
  logic [ACT_W-1:0]    rd_act_r, rd_act_nxt;
  logic                iss_done_r, iss_done_nxt;
  logic                pipe_vld_r, pipe_vld_nxt;
  logic [ACT_W-1:0]    pipe_act_r, pipe_act_nxt;
  logic                have_best_r, have_best_nxt;
  logic [ACT_W-1:0]    best_act_r, best_act_nxt;
  logic signed [15:0]  best_v_r, best_v_nxt;
  logic signed [15:0]  v_r, v_nxt;
  logic signed [33:0]  prod_r, prod_nxt;
  logic [VIS_W-1:0]    cnt_r, cnt_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   scan_addr;
  logic [ADDR_W-1:0]   upd_addr;
  logic [VAL_W-1:0]    wval;
  logic [VIS_W-1:0]    wvis;
  logic [VAL_W-1:0]    val_rdata;
  logic [VIS_W-1:0]    vis_rdata;
  logic signed [15:0]  sv;
  logic                take;
  logic [ACT_W-1:0]    b_act;
  logic signed [16:0]  diff;
  logic signed [17:0]  sh;
  logic signed [17:0]  sum;
  logic signed [15:0]  nv;

  assign scan_addr = ADDR_W'(32'(cur_r.ctx) * NUM_ACTIONS + 32'(rd_act_r));
  assign upd_addr  = ADDR_W'(32'(cur_r.ctx) * NUM_ACTIONS + 32'(cur_r.action));
  assign raddr     = (state_r == S_SCAN) ? scan_addr : upd_addr;

  ebb_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  ebb_ram #(.WIDTH(VIS_W), .DEPTH(TBL_DEPTH)) u_vis_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wvis),
    .raddr (raddr),
    .rdata (vis_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    rd_act_nxt    = rd_act_r;
    iss_done_nxt  = iss_done_r;
    pipe_vld_nxt  = 1'b0;
    pipe_act_nxt  = rd_act_r;
    have_best_nxt = have_best_r;
    best_act_nxt  = best_act_r;
    best_v_nxt    = best_v_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = upd_addr;
    wval          = '0;
    wvis          = '0;

    sv    = $signed(val_rdata);
    take  = cur_r.mask[pipe_act_r] && (!have_best_r || (sv > best_v_r));
    b_act = take ? pipe_act_r : best_act_r;
    diff  = {cur_r.reward[15], cur_r.reward} - {val_rdata[15], val_rdata};
    sh    = prod_r[33:16];
    sum   = {{2{v_r[15]}}, v_r} + sh;
    if (sum > 18'sd32767) begin
      nv = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      nv = -16'sh8000;
    end else begin
      nv = sum[15:0];
    end

    if (out_vld_r && out_pop) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == ADDR_W'(TBL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          unique case (q_item.kind)
            KIND_GREEDY: begin
              rd_act_nxt    = '0;
              iss_done_nxt  = 1'b0;
              have_best_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
            KIND_UPDATE: begin
              state_nxt = S_URD;
            end
            default: begin
              res_nxt   = q_item.res;
              state_nxt = S_PUSH;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!iss_done_r) begin
          pipe_vld_nxt = 1'b1;
          pipe_act_nxt = rd_act_r;
          if (rd_act_r == ACT_W'(NUM_ACTIONS - 1)) begin
            iss_done_nxt = 1'b1;
          end else begin
            rd_act_nxt = rd_act_r + 1'b1;
          end
        end
        if (pipe_vld_r) begin
          if (take) begin
            have_best_nxt = 1'b1;
            best_act_nxt  = pipe_act_r;
            best_v_nxt    = sv;
          end
          if (pipe_act_r == ACT_W'(NUM_ACTIONS - 1)) begin
            res_nxt               = '0;
            res_nxt.chosen_action = b_act;
            state_nxt             = S_PUSH;
          end
        end
      end
      S_URD: begin
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        v_nxt     = sv;
        prod_nxt  = diff * $signed({1'b0, cfg.alpha});
        cnt_nxt   = (vis_rdata == '1) ? vis_rdata : vis_rdata + 32'd1;
        state_nxt = S_UWR;
      end
      S_UWR: begin
        we                  = 1'b1;
        wval                = nv;
        wvis                = cnt_r;
        res_nxt             = '0;
        res_nxt.new_value   = nv;
        res_nxt.visit_total = cnt_r;
        state_nxt           = S_PUSH;
      end
      S_PUSH: begin
        if (!out_vld_r || out_pop) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      iss_done_r <= 1'b0;
      pipe_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      iss_done_r <= iss_done_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    rd_act_r    <= rd_act_nxt;
    pipe_act_r  <= pipe_act_nxt;
    have_best_r <= have_best_nxt;
    best_act_r  <= best_act_nxt;
    best_v_r    <= best_v_nxt;
    v_r         <= v_nxt;
    prod_r      <= prod_nxt;
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

endmodule

>>> design/epsilon_greedy_bandit_core.sv
// Epsilon-greedy contextual bandit with a value table and a visit-count table.
// Items enter through a queue-like port: an item is taken when in_push is high
// and in_full is low. Results leave the same way: out_item is valid while
// out_empty is low and is taken when out_pop is high.
// Configuration registers (epsilon, alpha, fallback action) are written on the
// cfg port, which is always ready; write them only while the block is idle.
// The front classifies each item on entry and resolves every select that needs
// no table value; a two-entry queue hands items to the back, which owns the
// tables. The back hands a resolved item straight on, runs an update as read,
// multiply, write and hand-off, and runs a greedy select as a scan that reads
// one table value per cycle from the value memory, followed by a hand-off.
// After reset a clearing pass writes zeros into both tables, one entry per
// cycle over all NUM_CONTEXTS * NUM_ACTIONS (128) entries; in_full stays high meanwhile.
// When the receiver stalls, one result waits in the output register, the back
// holds the next, and the front keeps taking items until its queue is full.
`include "assert_macros.svh"

module epsilon_greedy_bandit_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  ebb_pkg::in_item_t                   in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output ebb_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ebb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ebb_pkg::CFG_DAT_W-1:0]       cfg_data
);
  import ebb_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  q_item_t  q_item;
  logic     q_empty;
  logic     q_pop;
  logic     clearing;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EPSILON:  cfg_nxt.epsilon         = cfg_data;
        CFG_ALPHA:    cfg_nxt.alpha           = cfg_data;
        CFG_FALLBACK: cfg_nxt.fallback_action = cfg_data[2:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ebb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .hold    (clearing),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop)
  );

  ebb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  `ASSERT_CLKD(a_full_while_clear, clk, rst_n, clearing |-> in_full, "item port open during clear")
  `ASSERT_CLKD(a_no_result_while_clear, clk, rst_n, clearing |-> out_empty, "result during clear")
  `ASSERT_CLKD(a_accept_fills_queue, clk, rst_n, (in_push && !in_full) |=> !q_empty, "item lost")

endmodule

>>> tb/epsilon_greedy_bandit_core_tb.sv
module epsilon_greedy_bandit_core_tb;
  import ebb_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int LIMIT_TIME = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  in_item_t pending_items[$];
  out_item_t expected_results[$];

  logic signed [15:0] value_tbl[TBL_DEPTH];
  logic [31:0] visit_tbl[TBL_DEPTH];
  logic [15:0] eps_r = '0;
  logic [15:0] alpha_r = '0;
  logic [2:0] fallback_r = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  int mismatch_count = 0;
  int results_seen = 0;

  epsilon_greedy_bandit_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      value_tbl[i] = '0;
      visit_tbl[i] = '0;
    end
  end

  function automatic out_item_t predict_bandit(input in_item_t it);
    out_item_t res;
    int ctx, base, n, slot, best, a, k;
    int unsigned pick;
    int acts[NUM_ACTIONS];
    logic signed [15:0] bestv, v;
    longint diff, nv;
    res = '0;
    ctx = (it.context_req > NUM_CONTEXTS - 1) ? NUM_CONTEXTS - 1 : int'(it.context_req);
    base = ctx * NUM_ACTIONS;
    if (it.operation == OP_SELECT) begin
      n = 0;
      for (a = 0; a < NUM_ACTIONS; a++) begin
        if (it.feasible_mask[a]) begin
          acts[n] = a;
          n++;
        end
      end
      if (n == 0) begin
        res.chosen_action = fallback_r;
      end else if (n == 1) begin
        res.chosen_action = 3'(acts[0]);
      end else if (it.rand_explore < eps_r) begin
        pick = (int'(it.rand_pick) * n) >> 16;
        if (pick >= n) pick = n - 1;
        res.chosen_action = 3'(acts[pick]);
        res.explored = 1'b1;
      end else begin
        best = acts[0];
        bestv = value_tbl[base + acts[0]];
        for (k = 1; k < n; k++) begin
          v = value_tbl[base + acts[k]];
          if (v > bestv) begin
            bestv = v;
            best = acts[k];
          end
        end
        res.chosen_action = 3'(best);
      end
    end else if (it.taken_action >= NUM_ACTIONS) begin
      res.update_ignored = 1'b1;
    end else begin
      slot = base + int'(it.taken_action);
      diff = longint'($signed(it.reward)) - longint'($signed(value_tbl[slot]));
      nv = longint'($signed(value_tbl[slot])) + ((diff * longint'(alpha_r)) >>> 16);
      if (nv > 32767) nv = 32767;
      if (nv < -32768) nv = -32768;
      value_tbl[slot] = 16'(nv);
      if (visit_tbl[slot] != 32'hFFFF_FFFF) visit_tbl[slot] = visit_tbl[slot] + 1;
      res.new_value = value_tbl[slot];
      res.visit_total = visit_tbl[slot];
    end
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [0:0] op, input int ctx, input int mask,
                                         input int rexp, input int rpick, input int act,
                                         input int rew);
    in_item_t it;
    it.operation = op;
    it.context_req = 8'(ctx);
    it.feasible_mask = 8'(mask);
    it.rand_explore = 16'(rexp);
    it.rand_pick = 16'(rpick);
    it.taken_action = 4'(act);
    it.reward = 16'(rew);
    return it;
  endfunction

  function automatic in_item_t random_item(input int ctx_hi);
    in_item_t it;
    it.operation = ($urandom_range(99) < 50) ? OP_SELECT : OP_UPDATE;
    it.context_req = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(ctx_hi));
    case ($urandom_range(9))
      0: it.feasible_mask = 8'h00;
      1: it.feasible_mask = 8'(1 << $urandom_range(7));
      2: it.feasible_mask = 8'hFF;
      default: it.feasible_mask = 8'($urandom_range(255));
    endcase
    it.rand_explore = 16'($urandom_range(65535));
    it.rand_pick = 16'($urandom_range(65535));
    it.taken_action = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(NUM_ACTIONS - 1));
    case ($urandom_range(9))
      0: it.reward = 16'h7FFF;
      1: it.reward = 16'h8000;
      2: it.reward = 16'(int'($urandom_range(511)) - 256);
      default: it.reward = 16'($urandom_range(65535));
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_EPSILON: eps_r = data;
      CFG_ALPHA: alpha_r = data;
      CFG_FALLBACK: fallback_r = data[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int eps, input int alp, input int fb, input int sidle,
                           input int rstall, input int count, input int ctx_hi,
                           input bit pressure);
    write_reg(CFG_EPSILON, 16'(eps));
    write_reg(CFG_ALPHA, 16'(alp));
    write_reg(CFG_FALLBACK, 16'(fb));
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < count; i++) pending_items.push_back(random_item(ctx_hi));
    if (pressure) hold_go = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expected_results.push_back(predict_bandit(in_item));
        pending_items.delete(0);
      end
      if (!(in_push && in_full)) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_item.chosen_action !== want.chosen_action)
          report_mismatch($sformatf("chosen_action got %0d want %0d",
                                    out_item.chosen_action, want.chosen_action));
        if (out_item.explored !== want.explored)
          report_mismatch($sformatf("explored got %0b want %0b",
                                    out_item.explored, want.explored));
        if (out_item.new_value !== want.new_value)
          report_mismatch($sformatf("new_value got %0d want %0d",
                                    out_item.new_value, want.new_value));
        if (out_item.visit_total !== want.visit_total)
          report_mismatch($sformatf("visit_total got %0d want %0d",
                                    out_item.visit_total, want.visit_total));
        if (out_item.update_ignored !== want.update_ignored)
          report_mismatch($sformatf("update_ignored got %0b want %0b",
                                    out_item.update_ignored, want.update_ignored));
      end
    end
    out_pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_TIME);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (in_full) @(posedge clk);

    // Defaults after reset: fallback zero and no learning.
    pending_items.push_back(make_item(OP_SELECT, 0, 8'h00, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_UPDATE, 0, 8'h00, 0, 0, 2, 32767));
    pending_items.push_back(make_item(OP_SELECT, 0, 8'hFF, 0, 0, 0, 0));
    wait_drained();

    write_reg(CFG_EPSILON, 16'h8000);
    write_reg(CFG_ALPHA, 16'h8000);
    write_reg(CFG_FALLBACK, 16'd5);
    pending_items.push_back(make_item(OP_SELECT, 3, 8'h00, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'h10, 0, 65535, 0, 0));
    pending_items.push_back(make_item(OP_UPDATE, 3, 8'h00, 0, 0, 6, 32767));
    pending_items.push_back(make_item(OP_UPDATE, 3, 8'h00, 0, 0, 1, -32768));
    pending_items.push_back(make_item(OP_UPDATE, 3, 8'hFF, 0, 0, 15, 1000));
    pending_items.push_back(make_item(OP_UPDATE, 3, 8'hFF, 0, 0, 8, 1000));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'hFF, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'h03, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'hFF, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'hFF, 32767, 65535, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 3, 8'hA5, 32768, 0, 0, 0));
    pending_items.push_back(make_item(OP_UPDATE, 255, 8'h00, 0, 0, 7, 16'h1234));
    pending_items.push_back(make_item(OP_SELECT, 255, 8'h81, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 16, 8'hC0, 0, 32768, 0, 0));
    pending_items.push_back(make_item(OP_UPDATE, 0, 8'h00, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_UPDATE, 0, 8'h00, 0, 0, 0, -1));
    pending_items.push_back(make_item(OP_UPDATE, 0, 8'h00, 0, 0, 0, -1));
    pending_items.push_back(make_item(OP_UPDATE, 5, 8'h00, 0, 0, 2, 100));
    pending_items.push_back(make_item(OP_UPDATE, 5, 8'h00, 0, 0, 4, 100));
    pending_items.push_back(make_item(OP_SELECT, 5, 8'h14, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_SELECT, 5, 8'hFF, 65535, 0, 0, 0));
    wait_drained();

    run_phase(16'h4000, 16'h2000, 3, 0, 0, 300, 15, 1'b0);
    run_phase(65535, 65535, 7, 74, 0, 250, 3, 1'b0);
    run_phase(0, 0, 0, 0, 74, 250, 15, 1'b0);
    run_phase(16'h1000, 16'h8000, 6, 25, 25, 300, 1, 1'b0);
    run_phase(16'h8000, 16'h0100, 1, 0, 0, 200, 2, 1'b1);
    run_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(7), 25, 25, 250,
              15, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ebb_pkg.sv
design/ebb_ram.sv
design/ebb_front.sv
design/ebb_back.sv
design/epsilon_greedy_bandit_core.sv
tb/epsilon_greedy_bandit_core_tb.sv
